@@ rtl/psdr_pkg.sv @@
// Shared types and constants of the periodic sample decimal reporter.
package psdr_pkg;

    // Field widths
    localparam int SAMPLE_IN_W = 10;
    localparam int CHAR_W      = 8;
    localparam int PERIOD_W    = 16;

    // Default width of the held sample store
    localparam int SAMPLE_BITS_DEF = 10;

    // Reported value never exceeds four decimal digits
    localparam int MAX_DIGITS  = 4;
    localparam int VAL_W       = 14;
    localparam int DIG_W       = 4;
    localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam logic [PERIOD_W-1:0] MAX_SHOWN = 16'd9999;

    // Period after reset
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd250;

    // Reciprocal for divide by ten: q = (v * DIV10_MUL) >> DIV10_SHIFT,
    // exact for every v up to 43698
    localparam int DIV10_SHIFT = 19;
    localparam logic [15:0] DIV10_MUL = 16'd52429;

    // Characters
    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE   = 8'd57;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

    // Commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // One report job passed from the front end to the converter
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
    } job_t;

endpackage

@@ rtl/psdr_in_if.sv @@
// Input item channel: command and converter sample.
interface psdr_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [psdr_pkg::SAMPLE_IN_W-1:0]   sample_value;

    modport source (output valid, output command, output sample_value, input ready);
    modport sink   (input valid, input command, input sample_value, output ready);
endinterface

@@ rtl/psdr_out_if.sv @@
// Output character channel: one ASCII character per transfer.
interface psdr_out_if;
    logic                           valid;
    logic                           ready;
    logic [psdr_pkg::CHAR_W-1:0]    ascii_char;
    logic                           last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

@@ rtl/psdr_front.sv @@
// Front end: holds the latest sample, counts ticks and raises report jobs.
module psdr_front #(
    parameter int SAMPLE_BITS = psdr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    psdr_in_if.sink                         item_ch,
    input  logic                            cfg_we,
    input  logic [psdr_pkg::PERIOD_W-1:0]   cfg_wdata,
    input  logic                            queue_full,
    output psdr_pkg::job_t                  push_job
);

    logic [SAMPLE_BITS-1:0]             held_reg, held_next;
    logic [psdr_pkg::PERIOD_W-1:0]      count_reg, count_next;
    logic [psdr_pkg::PERIOD_W-1:0]      period_reg;
    logic [psdr_pkg::PERIOD_W-1:0]      count_inc;
    logic [SAMPLE_BITS+psdr_pkg::SAMPLE_IN_W-1:0] sample_ext;
    logic [SAMPLE_BITS+psdr_pkg::PERIOD_W-1:0]    held_ext;
    logic [psdr_pkg::PERIOD_W-1:0]      held16;
    logic                               xfer;
    logic                               report;

    assign item_ch.ready = !queue_full;
    assign xfer          = item_ch.valid && item_ch.ready;

    // Sample masked or zero-extended to the store width
    assign sample_ext = {{SAMPLE_BITS{1'b0}}, item_ch.sample_value};

    // Held value widened or cut to sixteen bits for the saturation below
    assign held_ext = {{psdr_pkg::PERIOD_W{1'b0}}, held_reg};
    assign held16   = held_ext[psdr_pkg::PERIOD_W-1:0];

    // Prescaler compare
    assign count_inc = count_reg + 16'd1;
    assign report    = (count_inc >= period_reg);

    always_comb
    begin
        held_next      = held_reg;
        count_next     = count_reg;
        push_job.valid = 1'b0;
        if (held16 > psdr_pkg::MAX_SHOWN)
        begin
            push_job.value = psdr_pkg::MAX_SHOWN[psdr_pkg::VAL_W-1:0];
        end
        else
        begin
            push_job.value = held16[psdr_pkg::VAL_W-1:0];
        end
        if (xfer)
        begin
            case (item_ch.command)
                psdr_pkg::CMD_SAMPLE:
                begin
                    held_next = sample_ext[SAMPLE_BITS-1:0];
                end
                psdr_pkg::CMD_TICK:
                begin
                    if (report)
                    begin
                        count_next     = '0;
                        push_job.valid = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // State and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            count_reg  <= '0;
            period_reg <= psdr_pkg::PERIOD_RESET;
        end
        else
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
        end
    end

endmodule

@@ rtl/psdr_queue.sv @@
// Two-entry job queue between front end and converter.
module psdr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  psdr_pkg::job_t  push_job,
    output logic            full,
    output psdr_pkg::job_t  head_job,
    input  logic            pop
);

    logic [psdr_pkg::VAL_W-1:0] slot_reg [2];
    logic                       wr_ptr_reg, wr_ptr_next;
    logic                       rd_ptr_reg, rd_ptr_next;
    logic [1:0]                 fill_reg, fill_next;
    logic                       do_push;
    logic                       do_pop;

    assign full           = (fill_reg == 2'd2);
    assign do_push        = push_job.valid && !full;
    assign do_pop         = pop && (fill_reg != 2'd0);
    assign head_job.valid = (fill_reg != 2'd0);
    assign head_job.value = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job.value;
        end
    end

endmodule

@@ rtl/psdr_back.sv @@
// Back end: splits a value into decimal digits and sends them as characters.
module psdr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  psdr_pkg::job_t  head_job,
    output logic            pop,
    psdr_out_if.source      char_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int PROD_W = psdr_pkg::VAL_W + 16;

    logic [1:0]                                 state_reg, state_next;
    logic [psdr_pkg::VAL_W-1:0]                 val_reg, val_next;
    logic [psdr_pkg::MAX_DIGITS-1:0][psdr_pkg::DIG_W-1:0] dig_reg, dig_next;
    logic [psdr_pkg::DIG_CNT_W-1:0]             nd_reg, nd_next;
    logic                                       valid_reg, valid_next;
    logic [psdr_pkg::CHAR_W-1:0]                char_reg, char_next;
    logic                                       last_reg, last_next;
    logic [PROD_W-1:0]                          prod;
    logic [psdr_pkg::VAL_W-1:0]                 quot;
    logic [psdr_pkg::VAL_W-1:0]                 rem;
    logic                                       load;

    assign char_ch.valid      = valid_reg;
    assign char_ch.ascii_char = char_reg;
    assign char_ch.last       = last_reg;

    // One divide-by-ten step per cycle
    assign prod = PROD_W'(val_reg) * PROD_W'(psdr_pkg::DIV10_MUL);
    assign quot = psdr_pkg::VAL_W'(prod >> psdr_pkg::DIV10_SHIFT);
    assign rem  = val_reg - ((quot << 3) + (quot << 1));

    // Output register takes a new character when empty or being drained
    assign load = !valid_reg || char_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        dig_next   = dig_reg;
        nd_next    = nd_reg;
        valid_next = valid_reg && !char_ch.ready;
        char_next  = char_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_job.valid)
                begin
                    pop        = 1'b1;
                    val_next   = head_job.value;
                    nd_next    = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Least significant digit enters at the top and moves down
                dig_next = {rem[psdr_pkg::DIG_W-1:0],
                            dig_reg[psdr_pkg::MAX_DIGITS-1:1]};
                val_next = quot;
                nd_next  = nd_reg + 1'b1;
                if ((quot == '0) ||
                    (nd_next == psdr_pkg::DIG_CNT_W'(psdr_pkg::MAX_DIGITS)))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    if (nd_reg != '0)
                    begin
                        // Most significant digit sits at the top
                        char_next = psdr_pkg::ASCII_ZERO +
                                    psdr_pkg::CHAR_W'(dig_reg[psdr_pkg::MAX_DIGITS-1]);
                        last_next = 1'b0;
                        dig_next  = {dig_reg[psdr_pkg::MAX_DIGITS-2:0],
                                     {psdr_pkg::DIG_W{1'b0}}};
                        nd_next   = nd_reg - 1'b1;
                    end
                    else
                    begin
                        char_next  = psdr_pkg::NEWLINE_CHAR;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            nd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            nd_reg    <= nd_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

@@ rtl/periodic_sample_decimal_reporter_core.sv @@
// Periodic sample decimal reporter: front end, job queue and decimal converter.
// Samples and non-reporting ticks are taken every cycle while the two-entry job queue has room.
// A reporting tick of a d-digit value (d = 1..4) queues a job; the converter pops it,
// runs one divide-by-ten step per digit, then sends the d digits and a newline at one
// character per cycle while the receiver is ready, and pops no new job until it has
// loaded the newline.
// Reset (rst_n low, asynchronous) clears the held sample and tick count, sets the period to 250.
module periodic_sample_decimal_reporter_core #(
    parameter int SAMPLE_BITS = psdr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    psdr_in_if.sink                         item_ch,
    psdr_out_if.source                      char_ch,
    input  logic                            cfg_we,
    input  logic [psdr_pkg::PERIOD_W-1:0]   cfg_wdata
);

    psdr_pkg::job_t push_job;
    psdr_pkg::job_t head_job;
    logic           queue_full;
    logic           pop;

    psdr_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .queue_full (queue_full),
        .push_job   (push_job)
    );

    psdr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_job (push_job),
        .full     (queue_full),
        .head_job (head_job),
        .pop      (pop)
    );

    psdr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .pop      (pop),
        .char_ch  (char_ch)
    );

    // A job is never raised while the queue is full
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_job.valid |-> !queue_full)
        else $error("report job raised with queue full");

    // A queued job always carries a value of at most four digits
    a_job_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_job.valid |-> (head_job.value <= psdr_pkg::MAX_SHOWN[psdr_pkg::VAL_W-1:0]))
        else $error("queued value exceeds four digits");

    // The closing character is a newline, every other one a digit
    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (char_ch.valid && char_ch.last) |-> (char_ch.ascii_char == psdr_pkg::NEWLINE_CHAR))
        else $error("last character is not a newline");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (char_ch.valid && !char_ch.last) |->
            ((char_ch.ascii_char >= psdr_pkg::ASCII_ZERO) &&
             (char_ch.ascii_char <= psdr_pkg::ASCII_NINE)))
        else $error("digit character out of range");

endmodule

@@ verif/tb_periodic_sample_decimal_reporter_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the periodic sample decimal reporter core.
module tb_periodic_sample_decimal_reporter_core;

    localparam int SAMPLE_BITS   = psdr_pkg::SAMPLE_BITS_DEF;
    localparam int IDLE_PCT      = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int CHUNK_ITEMS   = 19;
    localparam int N_CHUNKS      = 6;

    typedef struct packed {
        logic [psdr_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } char_rec_t;

    typedef struct {
        logic                             cmd;
        logic [psdr_pkg::SAMPLE_IN_W-1:0] smp;
        string                            want;
    } stim_row_t;

    // Directed rows, run at a period of one; typed text only where obvious
    stim_row_t dir_rows [22] = '{
        '{psdr_pkg::CMD_TICK,   10'd0,    "0\n"},
        '{psdr_pkg::CMD_SAMPLE, 10'd1023, ""},
        '{psdr_pkg::CMD_TICK,   10'd0,    "1023\n"},
        '{psdr_pkg::CMD_SAMPLE, 10'd0,    ""},
        '{psdr_pkg::CMD_TICK,   10'd1023, "0\n"},
        '{psdr_pkg::CMD_SAMPLE, 10'd9,    ""},
        '{psdr_pkg::CMD_TICK,   10'd0,    ""},
        '{psdr_pkg::CMD_SAMPLE, 10'd10,   ""},
        '{psdr_pkg::CMD_TICK,   10'd0,    ""},
        '{psdr_pkg::CMD_SAMPLE, 10'd99,   ""},
        '{psdr_pkg::CMD_TICK,   10'd0,    ""},
        '{psdr_pkg::CMD_SAMPLE, 10'd100,  ""},
        '{psdr_pkg::CMD_TICK,   10'd0,    ""},
        '{psdr_pkg::CMD_SAMPLE, 10'd999,  ""},
        '{psdr_pkg::CMD_TICK,   10'd0,    ""},
        '{psdr_pkg::CMD_SAMPLE, 10'd1000, ""},
        '{psdr_pkg::CMD_TICK,   10'd0,    ""},
        '{psdr_pkg::CMD_SAMPLE, 10'h155,  ""},
        '{psdr_pkg::CMD_SAMPLE, 10'h2AA,  ""},
        '{psdr_pkg::CMD_TICK,   10'd0,    ""},
        '{psdr_pkg::CMD_SAMPLE, 10'd1,    ""},
        '{psdr_pkg::CMD_TICK,   10'h3FF,  ""}
    };

    localparam logic [psdr_pkg::SAMPLE_IN_W-1:0] CORNER_SAMPLES [8] =
        '{10'd0, 10'd1023, 10'd9, 10'd10, 10'd99, 10'd100, 10'd999, 10'd1000};
    localparam logic [psdr_pkg::PERIOD_W-1:0] PERIOD_PLAN [N_CHUNKS-1] =
        '{16'd1, 16'd3, 16'd0, 16'd2, 16'd7};

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [psdr_pkg::PERIOD_W-1:0] cfg_wdata;

    psdr_in_if  item_ch();
    psdr_out_if char_ch();

    // Predictor state
    logic [SAMPLE_BITS-1:0]        held_val;
    logic [psdr_pkg::PERIOD_W-1:0] tick_cnt;
    logic [psdr_pkg::PERIOD_W-1:0] period_reg;
    int                            reports_made;

    char_rec_t report_q [$];
    int        errors;
    bit        quiet;
    int        hold_reqs;

    periodic_sample_decimal_reporter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .char_ch   (char_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Next state of the reporter for one item; text is the report, or empty
    task automatic predict_item(input logic cmd,
                                input logic [psdr_pkg::SAMPLE_IN_W-1:0] smp,
                                output string text);
        logic [psdr_pkg::VAL_W-1:0] shown;
        text = "";
        if (cmd == psdr_pkg::CMD_SAMPLE)
        begin
            held_val = smp[SAMPLE_BITS-1:0];
        end
        else
        begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= period_reg)
            begin
                tick_cnt = '0;
                shown = (held_val > psdr_pkg::MAX_SHOWN) ?
                        psdr_pkg::VAL_W'(psdr_pkg::MAX_SHOWN) :
                        psdr_pkg::VAL_W'(held_val);
                text = $sformatf("%0d\n", shown);
                reports_made++;
            end
        end
    endtask

    // Offer one item, wait for its transfer, queue the characters it causes
    task automatic put_item(input logic cmd, input logic [psdr_pkg::SAMPLE_IN_W-1:0] smp,
                            input string want);
        string text;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.command      <= cmd;
        item_ch.sample_value <= smp;
        do @(posedge clk); while (!item_ch.ready);
        predict_item(cmd, smp, text);
        if (want.len() != 0)
            text = want;
        for (int i = 0; i < text.len(); i++)
            report_q.push_back('{text[i], i == text.len() - 1});
    endtask

    // Sender goes quiet until every queued character has come out
    task automatic drain_reports();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (report_q.size() != 0);
    endtask

    // Period write, only with the block idle
    task automatic set_period(input logic [psdr_pkg::PERIOD_W-1:0] value);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        period_reg = value;
    endtask

    function automatic logic [psdr_pkg::SAMPLE_IN_W-1:0] pick_sample();
        if ($urandom_range(3) == 0)
            pick_sample = CORNER_SAMPLES[$urandom_range(7)];
        else
            pick_sample = psdr_pkg::SAMPLE_IN_W'($urandom_range(1023));
    endfunction

    // Stimulus
    initial
    begin : stimulus
        rst_n                = 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.command      <= psdr_pkg::CMD_SAMPLE;
        item_ch.sample_value <= '0;
        held_val     = '0;
        tick_cnt     = '0;
        period_reg   = psdr_pkg::PERIOD_RESET;
        reports_made = 0;
        errors       = 0;
        quiet        = 1'b0;
        hold_reqs    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Period after reset, no idling on either side: one report of zero
        quiet = 1'b1;
        repeat (psdr_pkg::PERIOD_RESET)
            put_item(psdr_pkg::CMD_TICK, psdr_pkg::SAMPLE_IN_W'($urandom_range(1023)), "");
        quiet = 1'b0;

        // Directed table at a period of one
        set_period(16'd1);
        foreach (dir_rows[i])
            put_item(dir_rows[i].cmd, dir_rows[i].smp, dir_rows[i].want);

        // Period of zero: every tick reports; receiver holds off meanwhile
        set_period(16'd0);
        hold_reqs++;
        repeat (20) put_item(logic'($urandom_range(1)), pick_sample(), "");

        // Largest period, then lowered below the running count
        set_period(16'hFFFF);
        repeat (12) put_item(psdr_pkg::CMD_TICK, '0, "");
        put_item(psdr_pkg::CMD_SAMPLE, 10'd512, "");
        set_period(16'd5);
        put_item(psdr_pkg::CMD_TICK, '0, "");

        // Random items in chunks, one period per chunk
        for (int c = 0; c < N_CHUNKS; c++)
        begin
            if (c < N_CHUNKS - 1)
                set_period(PERIOD_PLAN[c]);
            else
                set_period(psdr_pkg::PERIOD_W'($urandom_range(12, 1)));
            for (int k = 0; k < CHUNK_ITEMS; k++)
            begin
                // sender waits for every report to come out
                if (c == 3 && k == 10)
                    drain_reports();
                put_item(($urandom_range(99) < 55) ? psdr_pkg::CMD_TICK : psdr_pkg::CMD_SAMPLE,
                         pick_sample(), "");
            end
        end

        // Wind down
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && report_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Character receiver and checker
    initial
    begin : char_sink
        int        hold_left;
        int        hold_seen;
        char_rec_t want;
        hold_left = 0;
        hold_seen = 0;
        char_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (char_ch.valid && char_ch.ready)
            begin
                if (report_q.size() == 0)
                begin
                    $display("%0t: unexpected char expected none actual %0d last %0b",
                             $time, char_ch.ascii_char, char_ch.last);
                    errors++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (char_ch.ascii_char !== want.ch)
                    begin
                        $display("%0t: ascii_char mismatch expected %0d actual %0d",
                                 $time, want.ch, char_ch.ascii_char);
                        errors++;
                    end
                    if (char_ch.last !== want.last)
                    begin
                        $display("%0t: last mismatch expected %0b actual %0b",
                                 $time, want.last, char_ch.last);
                        errors++;
                    end
                end
            end
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                char_ch.ready <= 1'b0;
            end
            else
            begin
                char_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (char_ch.valid && char_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

@@ files.f @@
rtl/psdr_pkg.sv
rtl/psdr_in_if.sv
rtl/psdr_out_if.sv
rtl/psdr_front.sv
rtl/psdr_queue.sv
rtl/psdr_back.sv
rtl/periodic_sample_decimal_reporter_core.sv
verif/tb_periodic_sample_decimal_reporter_core.sv
